>>> rtl/core/bia_pkg.sv
package bia_pkg;

  // Map geometry and field widths
  localparam int WORD_BITS   = 64;
  localparam int BIT_SEL_W   = 6;
  localparam int IDX_W       = 10;
  localparam int CFG_W       = 11;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 9;

  localparam logic [CFG_W-1:0] BITS_IN_USE_RESET = 11'd1024;

  // Request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_IGNORED = 2'd3
  } status_code_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/bia_ctrl.sv
module bia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bia_pkg::dp_status_t dp_status,
  output bia_pkg::dp_cmd_t    dp_cmd
);
  import bia_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Accept only when no transaction is in flight
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold until the output register can take the result
        if (dp_status.out_free) begin
          dp_cmd.commit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/bia_datapath.sv
module bia_datapath #(
  parameter int MAX_WORDS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bia_pkg::dp_cmd_t              dp_cmd,
  output bia_pkg::dp_status_t           dp_status,
  input  logic                          cmd,
  input  logic [bia_pkg::IDX_W-1:0]     free_index,
  input  logic                          cfg_we,
  input  logic [bia_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [bia_pkg::IDX_W-1:0]     granted_index,
  output logic [bia_pkg::STATUS_W-1:0]  status
);
  import bia_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int FW = (AW + BIT_SEL_W > CFG_W) ? AW + BIT_SEL_W : CFG_W;

  // Map storage, per-word written flags and nonzero summary
  logic [WORD_BITS-1:0] mem [MAX_WORDS];
  logic [MAX_WORDS-1:0] written;
  logic [MAX_WORDS-1:0] nonzero;

  logic [CFG_W-1:0]     bits_in_use;
  logic [CNT_W-1:0]     words_used;
  logic [CFG_W:0]       bits_round;
  logic [MAX_WORDS-1:0] in_use;
  logic [MAX_WORDS-1:0] cand;
  logic [MAX_WORDS-1:0] cand_low;
  logic [AW-1:0]        first_word;
  logic [CNT_W-1:0]     free_word;
  logic                 no_word;
  logic                 free_out;
  logic [AW-1:0]        rd_addr;

  // Captured transaction
  logic                 cmd_r;
  logic [BIT_SEL_W-1:0] bit_r;
  logic [AW-1:0]        addr_r;
  logic                 full_r;
  logic                 ignore_r;
  logic [WORD_BITS-1:0] rd_word;
  logic                 rd_written;

  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] low_bit;
  logic [BIT_SEL_W-1:0] low_idx;
  logic [FW-1:0]        found;
  logic                 beyond;
  logic [WORD_BITS-1:0] alloc_word;
  logic [WORD_BITS-1:0] free_word_val;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  status_code_t         res_status;
  logic [IDX_W-1:0]     res_index;

  // Words in use, rounded up and capped at the map depth
  assign bits_round = {1'b0, bits_in_use} + (CFG_W+1)'(WORD_BITS - 1);
  always_comb begin
    logic [CNT_W-1:0] raw;
    raw = CNT_W'(bits_round[CFG_W:BIT_SEL_W]);
    if (raw > CNT_W'(MAX_WORDS)) begin
      words_used = CNT_W'(MAX_WORDS);
    end else begin
      words_used = raw;
    end
  end

  // Mark words in use and isolate the first nonzero one
  always_comb begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      in_use[i] = (CNT_W'(i) < words_used);
    end
  end

  assign cand     = nonzero & in_use;
  assign cand_low = cand & (~cand + MAX_WORDS'(1));
  assign no_word  = (cand == '0);

  // Encode the one-hot word select
  always_comb begin
    logic [CNT_W-1:0] pos;
    first_word = '0;
    for (int k = 0; k < AW; k++) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        pos = CNT_W'(i);
        if (pos[k]) begin
          first_word[k] = first_word[k] | cand_low[i];
        end
      end
    end
  end

  assign free_word = CNT_W'(free_index[IDX_W-1:BIT_SEL_W]);
  assign free_out  = (free_word >= words_used);

  // Pick the word to read; park the address when nothing is touched
  always_comb begin
    if (cmd == CMD_FREE) begin
      rd_addr = free_out ? '0 : free_word[AW-1:0];
    end else begin
      rd_addr = no_word ? '0 : first_word;
    end
  end

  // Capture the request and read its map word
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r      <= cmd;
      bit_r      <= free_index[BIT_SEL_W-1:0];
      addr_r     <= rd_addr;
      full_r     <= no_word;
      ignore_r   <= free_out;
      rd_word    <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  // A word never written still holds its reset value of all ones
  assign cur_word = rd_written ? rd_word : '1;

  // Lowest set bit of the word
  assign low_bit = cur_word & (~cur_word + WORD_BITS'(1));
  always_comb begin
    logic [BIT_SEL_W-1:0] pos;
    low_idx = '0;
    for (int k = 0; k < BIT_SEL_W; k++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        pos = BIT_SEL_W'(i);
        if (pos[k]) begin
          low_idx[k] = low_idx[k] | low_bit[i];
        end
      end
    end
  end

  assign found         = FW'({addr_r, low_idx});
  assign beyond        = (found >= FW'(bits_in_use));
  assign alloc_word    = cur_word & ~low_bit;
  assign free_word_val = cur_word | (WORD_BITS'(1) << bit_r);

  // Resolve the result and the write-back
  always_comb begin
    wr_en      = 1'b0;
    wr_data    = free_word_val;
    res_index  = '0;
    res_status = ST_DONE;
    if (cmd_r == CMD_FREE) begin
      if (ignore_r) begin
        res_status = ST_IGNORED;
      end else begin
        wr_en = 1'b1;
      end
    end else begin
      if (full_r) begin
        res_status = ST_FULL;
      end else if (beyond) begin
        res_status = ST_RANGE;
      end else begin
        wr_en     = 1'b1;
        wr_data   = alloc_word;
        res_index = found[IDX_W-1:0];
      end
    end
  end

  // Write back the map word
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && wr_en) begin
      mem[addr_r] <= wr_data;
    end
  end

  // Advance the written flags and the nonzero summary
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      nonzero <= '1;
    end else if (dp_cmd.commit && wr_en) begin
      written[addr_r] <= 1'b1;
      nonzero[addr_r] <= (wr_data != '0);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= BITS_IN_USE_RESET;
    end else if (cfg_we) begin
      bits_in_use <= cfg_data;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      granted_index <= res_index;
      status        <= res_status;
    end
  end

  assign dp_status.out_free = !out_valid || !out_stall;

endmodule

>>> rtl/core/bitmap_index_allocator.sv
// Bitmap index allocator: hands out and takes back indices from a free map
// of 64-bit words, a set bit meaning the index is free.
// Input channel (in_valid / in_stall): cmd selects allocate or free;
// free_index is used by free only. A transaction is taken when in_valid is
// high and in_stall is low.
// Output channel (out_valid / out_stall): one result per request,
// granted_index and status, held stable while out_stall is high.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes
// bits_in_use; cfg_ready is always high; write only while idle.
// A taken request is captured with its map word read, then resolved and
// committed to the output register, with the map word written back, once
// that register is free. No new request is taken until the last one is
// committed; a nonzero-word summary in flip-flops finds the word to
// allocate from combinationally.
// When the receiver stalls with a result pending, the block takes one more
// request and holds it; in_stall stays high until that result is taken.
// Reset (rst, synchronous): every index is free, bits_in_use is 1024;
// per-word written flags make the map read as all ones at once, with no
// clearing pass.
module bitmap_index_allocator #(
  parameter int MAX_WORDS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [bia_pkg::IDX_W-1:0]     free_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bia_pkg::IDX_W-1:0]     granted_index,
  output logic [bia_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bia_pkg::CFG_W-1:0]     cfg_data
);
  import bia_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  bia_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status),
    .cmd           (cmd),
    .free_index    (free_index),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .granted_index (granted_index),
    .status        (status)
  );

`ifndef ASSERT_OFF
  // A taken request keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in flight");

  // Only a successful allocate carries a nonzero index
  a_index_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> granted_index == '0)
    else $error("nonzero index with a failing status");

  // A new result appears only at the end of a request in flight
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");
`endif

endmodule

>>> test/tb_bitmap_index_allocator.sv
`timescale 1ns / 1ps

module tb_bitmap_index_allocator;
  import bia_pkg::*;

  localparam int MAP_WORDS   = 16;
  localparam int RAND_ITEMS  = 650;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;
  localparam int PLAN_ROWS   = 24;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [IDX_W-1:0] grant;
    status_code_t     st;
  } grant_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             op;
    logic [CFG_W-1:0] value;
    logic             typed;
    logic [IDX_W-1:0] grant;
    status_code_t     st;
  } row_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic                cmd        = CMD_ALLOC;
  logic [IDX_W-1:0]    free_index = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [IDX_W-1:0]    granted_index;
  logic [STATUS_W-1:0] status;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data   = '0;

  // Shadow copy of the free map and the bit count
  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  logic [CFG_W-1:0]     shadow_bits;
  grant_t               pending_grants [$];
  logic [IDX_W-1:0]     granted_pool [$];
  int                   mismatches = 0;
  logic                 tx_bursty  = 1'b0;
  logic                 rx_bursty  = 1'b0;
  logic                 hold_req   = 1'b0;
  logic                 hold_done  = 1'b0;
  int                   stall_left = 0;

  // Directed rows: typed results only where they are obvious
  row_t plan [PLAN_ROWS] = '{
    '{ROW_REQ, CMD_ALLOC, 11'd0,    1'b1, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd1023, 1'b1, 10'd1, ST_DONE},
    '{ROW_REQ, CMD_FREE,  11'd0,    1'b1, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd0,    1'b1, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_FREE,  11'd1023, 1'b1, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_FREE,  11'd1,    1'b1, 10'd0, ST_DONE},
    '{ROW_CFG, CMD_ALLOC, 11'd0,    1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd512,  1'b1, 10'd0, ST_FULL},
    '{ROW_REQ, CMD_FREE,  11'd1023, 1'b1, 10'd0, ST_IGNORED},
    '{ROW_REQ, CMD_FREE,  11'd0,    1'b1, 10'd0, ST_IGNORED},
    '{ROW_CFG, CMD_ALLOC, 11'd2047, 1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd0,    1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_FREE,  11'd1023, 1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd341,  1'b0, 10'd0, ST_DONE},
    '{ROW_CFG, CMD_ALLOC, 11'd1,    1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd0,    1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_FREE,  11'd0,    1'b1, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd682,  1'b1, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd0,    1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_FREE,  11'd63,   1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_FREE,  11'd64,   1'b1, 10'd0, ST_IGNORED},
    '{ROW_CFG, CMD_ALLOC, 11'd64,   1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd0,    1'b0, 10'd0, ST_DONE},
    '{ROW_REQ, CMD_ALLOC, 11'd1023, 1'b0, 10'd0, ST_DONE}
  };

  bitmap_index_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .free_index    (free_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted_index (granted_index),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

  // Compute the result of one request and advance the shadow map
  function automatic grant_t compute_grant(logic op, logic [IDX_W-1:0] idx);
    int     nwords;
    int     w;
    int     b;
    int     found;
    grant_t r;
    nwords = (int'(shadow_bits) + WORD_BITS - 1) / WORD_BITS;
    if (nwords > MAP_WORDS) nwords = MAP_WORDS;
    r.grant = '0;
    if (op == CMD_ALLOC) begin
      w = 0;
      while (w < nwords && shadow_map[w] == '0) w++;
      if (w == nwords) begin
        r.st = ST_FULL;
      end else begin
        b = 0;
        while (!shadow_map[w][b]) b++;
        found = w * WORD_BITS + b;
        // a stale bit past the count blocks the allocate, map untouched
        if (found >= int'(shadow_bits)) begin
          r.st = ST_RANGE;
        end else begin
          shadow_map[w][b] = 1'b0;
          r.grant = found[IDX_W-1:0];
          r.st = ST_DONE;
        end
      end
    end else if (int'(idx) / WORD_BITS >= nwords) begin
      r.st = ST_IGNORED;
    end else begin
      shadow_map[int'(idx) / WORD_BITS][int'(idx) % WORD_BITS] = 1'b1;
      r.st = ST_DONE;
    end
    return r;
  endfunction

  function automatic void note_mismatch(logic has_want, grant_t want);
    mismatches++;
    if (mismatches <= 10) begin
      if (has_want)
        $display("mismatch: expected index %0d status %0d, got index %0d status %0d",
                 want.grant, want.st, granted_index, status);
      else
        $display("mismatch: unexpected result index %0d status %0d", granted_index, status);
    end
  endfunction

  // Present one request and hold it until the transaction is taken
  task automatic send_request(logic op, logic [IDX_W-1:0] idx, logic typed, grant_t typed_res);
    grant_t r;
    if (tx_bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    free_index <= idx;
    do @(posedge clk); while (in_stall);
    r = compute_grant(op, idx);
    if (op == CMD_ALLOC && r.st == ST_DONE) granted_pool.push_back(r.grant);
    pending_grants.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (pending_grants.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Write the bit count once every result is out
  task automatic write_bits_in_use(logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_bits = value;
  endtask

  // Check results and generate receiver stalls
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          note_mismatch(1'b0, want);
        end else begin
          want = pending_grants.pop_front();
          if (granted_index !== want.grant || status !== want.st) note_mismatch(1'b1, want);
        end
      end
      if (hold_req && !hold_done) begin
        // long hold-off so the block fills and stalls its input
        hold_done  <= 1'b1;
        stall_left <= HOLD_CYCLES - 1;
        out_stall  <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 11);
        out_stall  <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
      end
    end
  end

  initial begin
    int               sent;
    int               span;
    int               alloc_pct;
    int               phase;
    int               hi;
    int               k;
    logic             closing;
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] setting;
    grant_t           typed_res;

    foreach (shadow_map[i]) shadow_map[i] = '1;
    shadow_bits = BITS_IN_USE_RESET;
    typed_res   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows with idling on both sides
    tx_bursty = 1'b1;
    rx_bursty <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_bits_in_use(plan[i].value);
      end else begin
        typed_res.grant = plan[i].grant;
        typed_res.st    = plan[i].st;
        send_request(plan[i].op, plan[i].value[IDX_W-1:0], plan[i].typed, typed_res);
      end
    end

    // Random phases, each under its own bit count
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       setting = 11'd0;
        1:       setting = 11'd1;
        2:       setting = 11'd64;
        3:       setting = 11'd2047;
        4:       setting = BITS_IN_USE_RESET;
        5:       setting = 11'd128;
        default: setting = CFG_W'($urandom_range(1, 1100));
      endcase
      span    = $urandom_range(40, 90);
      closing = (sent + span >= RAND_ITEMS);
      tx_bursty = !closing && ($urandom_range(0, 3) != 0);
      rx_bursty <= !closing && ($urandom_range(0, 3) != 0);
      write_bits_in_use(setting);
      if (phase == 2) begin
        tx_bursty = 1'b0;
        hold_req <= 1'b1;
      end
      alloc_pct = $urandom_range(40, 85);
      hi = (shadow_bits == 0) ? 0 : ((shadow_bits > 1023) ? 1023 : int'(shadow_bits) - 1);
      repeat (span) begin
        op  = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        idx = IDX_W'($urandom);
        if (op == CMD_FREE) begin
          case ($urandom_range(0, 3))
            0, 1: begin
              // return an index handed out earlier
              if (granted_pool.size() != 0) begin
                k   = $urandom_range(0, granted_pool.size() - 1);
                idx = granted_pool[k];
                granted_pool.delete(k);
              end
            end
            2:       idx = IDX_W'($urandom_range(0, hi));
            default: ;
          endcase
        end
        send_request(op, idx, 1'b0, typed_res);
        sent++;
      end
      phase++;
    end

    // Drain, let the block settle, then report
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
